### hdl/gsu_pkg.sv
// Shared types, constants and fixed-point helpers for the subspace update block.
package gsu_pkg;

  localparam int XW     = 16;  // Q4.12 sample and basis word
  localparam int ACCW   = 40;  // Q16.24 coefficient accumulator
  localparam int DW_D   = 32;  // Q28 direction element
  localparam int PRODW  = DW_D + XW;
  localparam int WIDEW  = 64;  // Headroom for saturating sums
  localparam int MAX_AW = 10;  // Row address field of the cell control
  localparam int MAX_CW = 6;   // Column field of the cell control

  localparam logic signed [WIDEW-1:0] SAT_HI = WIDEW'(2 ** (XW - 1) - 1);
  localparam logic signed [WIDEW-1:0] SAT_LO = ~SAT_HI;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_READ     = 2'd0,
    ST_UPDATED  = 2'd1,
    ST_SKIPPED  = 2'd2
  } status_e;

  // Operand selection of the multiplier in every cell.
  typedef enum logic [1:0] {
    MS_RD_B = 2'd0,  // basis word times broadcast sample
    MS_RD_Y = 2'd1,  // basis word times own coefficient
    MS_Y_Y  = 2'd2,  // own coefficient squared
    MS_B_Y  = 2'd3   // broadcast direction times own coefficient
  } mul_sel_e;

  typedef struct packed {
    logic                     rd_en;
    logic [MAX_AW-1:0]        addr;
    logic                     host_wr;
    logic [MAX_CW-1:0]        col;
    logic signed [XW-1:0]     wdata;
    mul_sel_e                 mul_sel;
    logic signed [DW_D-1:0]   bdata;
    logic                     acc_en;
    logic                     y_load;
    logic                     div_start;
    logic                     wb_en;
  } cell_ctl_t;

  function automatic logic signed [XW-1:0] sat_xw(input logic signed [WIDEW-1:0] v);
    logic signed [XW-1:0] res;
    if (v > SAT_HI) begin
      res = SAT_HI[XW-1:0];
    end else if (v < SAT_LO) begin
      res = SAT_LO[XW-1:0];
    end else begin
      res = v[XW-1:0];
    end
    return res;
  endfunction

  // Q16.24 to Q4.12: divide by 4096, round half away from zero, saturate.
  function automatic logic signed [XW-1:0] rnd_q12(input logic signed [ACCW-1:0] v);
    logic [ACCW-1:0]        mag;
    logic [ACCW-1:0]        q;
    logic signed [WIDEW-1:0] s;
    mag = v[ACCW-1] ? ACCW'(-v) : ACCW'(v);
    q   = (mag + ACCW'(2048)) >> 12;
    s   = v[ACCW-1] ? -$signed(WIDEW'(q)) : $signed(WIDEW'(q));
    return sat_xw(s);
  endfunction

endpackage

### hdl/grouse_subspace_update.sv
// Top level: request handshakes, update sequencer and the row of column cells.
// A basis write ends in the idle state; a basis read passes S_RD and S_EMIT, a
// sample element S_MUL and S_ACC. The element that ends a vector also runs the
// update, or skips it if P, R or Y is zero: projection of every row, three square
// roots, and per row two divisions in the shared divider plus one in every cell.
// The block takes one request at a time. rst_ni clears the accumulators, counts
// and control state at once; the basis and sample memories are not cleared.
module grouse_subspace_update import gsu_pkg::*; #(
  parameter int VEC_DIM = 64,
  parameter int RANK    = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic [5:0]           row_i,
  input  logic [2:0]           col_i,
  input  logic signed [15:0]   value_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   read_value_o,
  output logic [1:0]           status_o
);

  localparam int AW         = $clog2(VEC_DIM);
  localparam int CW         = (RANK > 1) ? $clog2(RANK) : 1;
  localparam int CNTW       = $clog2(VEC_DIM + 1);
  localparam int CHW        = 32 + $clog2(RANK + 1);
  localparam int PSW        = 31 + $clog2(VEC_DIM + 1);
  localparam int SW         = PSW + 6;
  localparam int RW         = ((SW + 17) / 2) * 2;
  localparam int RTW        = RW / 2;
  localparam int ZNW        = 56;
  localparam int CELL_DENW  = RTW + 8;
  localparam int CHAIN_WAIT = RANK + 2;
  localparam int PROJ_P     = RANK + 3;
  localparam int STW        = $clog2(RANK + 6);

  typedef enum logic [21:0] {
    S_IDLE  = 22'h000001,
    S_RD    = 22'h000002,
    S_MUL   = 22'h000004,
    S_ACC   = 22'h000008,
    S_LOADY = 22'h000010,
    S_YSUM  = 22'h000020,
    S_PROJ  = 22'h000040,
    S_PCHK  = 22'h000080,
    S_RT_P  = 22'h000100,
    S_RT_Y  = 22'h000200,
    S_RT_S  = 22'h000400,
    S_U_RD  = 22'h000800,
    S_U_ZST = 22'h001000,
    S_U_ZW  = 22'h002000,
    S_U_QST = 22'h004000,
    S_U_QW  = 22'h008000,
    S_U_D   = 22'h010000,
    S_U_MUL = 22'h020000,
    S_U_CST = 22'h040000,
    S_U_CW  = 22'h080000,
    S_U_WB  = 22'h100000,
    S_EMIT  = 22'h200000
  } state_e;

  state_e                  state_q;
  logic [STW-1:0]          step_q;
  logic [AW-1:0]           row_q;
  logic [CNTW-1:0]         len_q;
  logic                    end_q;
  logic [2:0]              col_q;
  logic                    inr_q;
  logic signed [XW-1:0]    x_q;
  logic signed [XW-1:0]    res_val_q;
  status_e                 res_st_q;
  logic                    out_valid_q;
  logic signed [XW-1:0]    out_val_q;
  status_e                 out_st_q;

  logic [CHW-1:0]          y2_q;
  logic [PSW-1:0]          p2_q;
  logic [PSW-1:0]          r2_q;
  logic signed [XW-1:0]    p_q;
  logic signed [XW-1:0]    r_q;
  logic signed [2*XW-1:0]  pp_q;
  logic signed [2*XW-1:0]  rr_q;
  logic [RTW-1:0]          pn_q;
  logic [RTW-1:0]          yn_q;
  logic [RTW-1:0]          sn_q;
  logic signed [ZNW:0]     z_q;
  logic signed [ZNW:0]     q_q;
  logic signed [DW_D-1:0]  d_q;
  logic signed [XW-1:0]    xs_q;
  logic signed [XW-1:0]    pm_q;
  logic signed [XW-1:0]    rm_q;

  // Sample elements of the current vector, and p and r of every row.
  logic signed [XW-1:0]    smem_q [VEC_DIM];
  logic [2*XW-1:0]         prm_q  [VEC_DIM];

  logic                    in_acc;
  logic                    inr;
  logic                    load_out;
  logic                    last_row;
  logic                    row_live;
  logic signed [XW-1:0]    p_c;
  logic signed [XW-1:0]    r_c;
  logic signed [XW-1:0]    x_c;
  logic [SW-1:0]           s_sum;
  logic                    sq_start;
  logic [RW-1:0]           sq_arg;
  logic                    sq_done;
  logic [RTW-1:0]          sq_root;
  logic                    dv_start;
  logic signed [ZNW-1:0]   dv_num;
  logic [RTW-1:0]          dv_den;
  logic                    dv_done;
  logic signed [ZNW:0]     dv_quo;
  logic signed [ZNW-1:0]   z_sum;
  logic [CELL_DENW-1:0]    cell_den;
  cell_ctl_t               ctl;

  logic signed [CHW-1:0]   chain [RANK+1];
  logic signed [XW-1:0]    cell_rd [RANK];
  logic [RANK-1:0]         cell_done;

  assign in_stall_o = state_q != S_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign inr        = (32'(row_i) < VEC_DIM) && (32'(col_i) < RANK);
  assign load_out   = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);
  assign last_row   = row_q == AW'(VEC_DIM - 1);
  assign row_live   = CNTW'(row_q) < len_q;

  // Projection of the current row from the end of the cell chain; elements
  // beyond the received length count as zero.
  assign p_c = rnd_q12(ACCW'(chain[RANK]));
  assign x_c = row_live ? xs_q : '0;
  assign r_c = sat_xw(WIDEW'(x_c) - WIDEW'(p_c));

  assign s_sum = (SW'(p2_q) << 4) + (SW'(p2_q) << 3) + SW'(p2_q) + (SW'(r2_q) << 4);
  assign z_sum = (ZNW'(pm_q) <<< 2) + ZNW'(pm_q) + (ZNW'(rm_q) <<< 2);
  assign cell_den = {yn_q, 8'b0};

  // Square roots run back to back: P, then Y, then the rotation norm.
  always_comb begin
    sq_start = 1'b0;
    sq_arg   = RW'(p2_q) << 16;
    case (state_q)
      S_PCHK: begin
        sq_start = (p2_q != '0) && (r2_q != '0) && (y2_q != '0);
        sq_arg   = RW'(p2_q) << 16;
      end
      S_RT_P: begin
        sq_start = sq_done;
        sq_arg   = RW'(y2_q) << 16;
      end
      S_RT_Y: begin
        sq_start = sq_done;
        sq_arg   = RW'(s_sum) << 16;
      end
      default: begin
        sq_start = 1'b0;
      end
    endcase
  end

  assign dv_start = (state_q == S_U_ZST) || (state_q == S_U_QST);
  assign dv_num   = (state_q == S_U_ZST) ? (z_sum <<< 36) : (ZNW'(pm_q) <<< 28);
  assign dv_den   = (state_q == S_U_ZST) ? sn_q : pn_q;

  // Control broadcast to all cells.
  always_comb begin
    ctl         = '0;
    ctl.mul_sel = MS_RD_B;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (op_i)
            OP_WRITE: begin
              ctl.host_wr = inr;
              ctl.addr    = MAX_AW'(AW'(row_i));
              ctl.col     = MAX_CW'(col_i);
              ctl.wdata   = value_i;
            end
            OP_READ: begin
              ctl.rd_en = 1'b1;
              ctl.addr  = MAX_AW'(AW'(row_i));
            end
            OP_SAMPLE: begin
              ctl.rd_en = 1'b1;
              ctl.addr  = MAX_AW'(AW'(len_q));
            end
            default: begin
              ctl.rd_en = 1'b0;
            end
          endcase
        end
      end
      S_MUL: begin
        ctl.bdata = DW_D'(x_q);
      end
      S_ACC: begin
        ctl.acc_en = 1'b1;
      end
      S_LOADY: begin
        ctl.y_load = 1'b1;
      end
      S_YSUM: begin
        ctl.mul_sel = MS_Y_Y;
      end
      S_PROJ: begin
        ctl.mul_sel = MS_RD_Y;
        ctl.rd_en   = step_q == '0;
        ctl.addr    = MAX_AW'(row_q);
      end
      S_U_RD: begin
        ctl.rd_en = 1'b1;
        ctl.addr  = MAX_AW'(row_q);
      end
      S_U_MUL: begin
        ctl.mul_sel = MS_B_Y;
        ctl.bdata   = d_q;
      end
      S_U_CST: begin
        ctl.div_start = 1'b1;
      end
      S_U_WB: begin
        ctl.wb_en = 1'b1;
        ctl.addr  = MAX_AW'(row_q);
      end
      default: begin
        ctl.rd_en = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      row_q   <= '0;
      len_q   <= '0;
      end_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (op_i)
              OP_READ: begin
                state_q <= S_RD;
              end
              OP_SAMPLE: begin
                end_q   <= last_i || (len_q == CNTW'(VEC_DIM - 1));
                len_q   <= len_q + CNTW'(1);
                state_q <= S_MUL;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_RD: begin
          state_q <= S_EMIT;
        end
        S_MUL: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          state_q <= end_q ? S_LOADY : S_IDLE;
        end
        S_LOADY: begin
          step_q  <= '0;
          state_q <= S_YSUM;
        end
        S_YSUM: begin
          step_q <= step_q + STW'(1);
          if (step_q == STW'(CHAIN_WAIT)) begin
            step_q  <= '0;
            row_q   <= '0;
            state_q <= S_PROJ;
          end
        end
        S_PROJ: begin
          step_q <= step_q + STW'(1);
          if (step_q == STW'(PROJ_P + 2)) begin
            step_q <= '0;
            row_q  <= row_q + AW'(1);
            if (last_row) begin
              row_q   <= '0;
              state_q <= S_PCHK;
            end
          end
        end
        S_PCHK: begin
          if (sq_start) begin
            state_q <= S_RT_P;
          end else begin
            len_q   <= '0;
            state_q <= S_EMIT;
          end
        end
        S_RT_P: begin
          if (sq_done) begin
            state_q <= S_RT_Y;
          end
        end
        S_RT_Y: begin
          if (sq_done) begin
            state_q <= S_RT_S;
          end
        end
        S_RT_S: begin
          if (sq_done) begin
            state_q <= S_U_RD;
          end
        end
        S_U_RD: begin
          state_q <= S_U_ZST;
        end
        S_U_ZST: begin
          state_q <= S_U_ZW;
        end
        S_U_ZW: begin
          if (dv_done) begin
            state_q <= S_U_QST;
          end
        end
        S_U_QST: begin
          state_q <= S_U_QW;
        end
        S_U_QW: begin
          if (dv_done) begin
            state_q <= S_U_D;
          end
        end
        S_U_D: begin
          state_q <= S_U_MUL;
        end
        S_U_MUL: begin
          state_q <= S_U_CST;
        end
        S_U_CST: begin
          state_q <= S_U_CW;
        end
        S_U_CW: begin
          if (&cell_done) begin
            state_q <= S_U_WB;
          end
        end
        S_U_WB: begin
          row_q <= row_q + AW'(1);
          if (last_row) begin
            row_q   <= '0;
            len_q   <= '0;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_U_RD;
          end
        end
        S_EMIT: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Data path registers and the two small memories.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_q <= col_i;
      inr_q <= inr;
      x_q   <= value_i;
      if (op_i == OP_SAMPLE) begin
        smem_q[AW'(len_q)] <= value_i;
      end
    end
    case (state_q)
      S_RD: begin
        res_val_q <= inr_q ? cell_rd[CW'(col_q)] : '0;
        res_st_q  <= ST_READ;
      end
      S_YSUM: begin
        if (step_q == STW'(CHAIN_WAIT)) begin
          y2_q <= chain[RANK];
          p2_q <= '0;
          r2_q <= '0;
        end
      end
      S_PROJ: begin
        if (step_q == '0) begin
          xs_q <= smem_q[row_q];
        end
        if (step_q == STW'(PROJ_P)) begin
          p_q           <= p_c;
          r_q           <= r_c;
          prm_q[row_q]  <= {p_c, r_c};
        end
        if (step_q == STW'(PROJ_P + 1)) begin
          pp_q <= p_q * p_q;
          rr_q <= r_q * r_q;
        end
        if (step_q == STW'(PROJ_P + 2)) begin
          p2_q <= p2_q + PSW'(pp_q);
          r2_q <= r2_q + PSW'(rr_q);
        end
      end
      S_PCHK: begin
        res_val_q <= '0;
        res_st_q  <= ST_SKIPPED;
      end
      S_RT_P: begin
        if (sq_done) begin
          pn_q <= sq_root;
        end
      end
      S_RT_Y: begin
        if (sq_done) begin
          yn_q <= sq_root;
        end
      end
      S_RT_S: begin
        if (sq_done) begin
          sn_q <= sq_root;
        end
      end
      S_U_RD: begin
        pm_q <= $signed(prm_q[row_q][2*XW-1:XW]);
        rm_q <= $signed(prm_q[row_q][XW-1:0]);
      end
      S_U_ZW: begin
        if (dv_done) begin
          z_q <= dv_quo;
        end
      end
      S_U_QW: begin
        if (dv_done) begin
          q_q <= dv_quo;
        end
      end
      S_U_D: begin
        d_q <= DW_D'(z_q - q_q);
      end
      S_U_WB: begin
        res_val_q <= '0;
        res_st_q  <= ST_UPDATED;
      end
      default: begin
        res_st_q <= res_st_q;
      end
    endcase
  end

  // Output register: a result waits here while the next request is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_val_q <= res_val_q;
      out_st_q  <= res_st_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_val_q;
  assign status_o     = out_st_q;

  gsu_isqrt #(
    .IW (RW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .arg_i   (sq_arg),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  gsu_div #(
    .NW (ZNW),
    .DW (RTW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .done_o  (dv_done),
    .quo_o   (dv_quo)
  );

  // Row of column cells; the chain sums one row's products from left to right.
  assign chain[0] = '0;

  for (genvar j = 0; j < RANK; j++) begin : g_cell
    gsu_cell #(
      .VEC_DIM (VEC_DIM),
      .J       (j),
      .CHW     (CHW),
      .DENW    (CELL_DENW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .den_i   (cell_den),
      .chain_i (chain[j]),
      .chain_o (chain[j+1]),
      .rdata_o (cell_rd[j]),
      .done_o  (cell_done[j])
    );
  end

endmodule

### hdl/gsu_div.sv
// Restoring divider with round-half-away-from-zero, one quotient bit per cycle.
module gsu_div import gsu_pkg::*; #(
  parameter int NW = 48,
  parameter int DW = 38
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [NW-1:0] num_i,
  input  logic [DW-1:0]        den_i,
  output logic                 done_o,
  output logic signed [NW:0]   quo_o
);

  localparam int CNTW = $clog2(NW + 2);

  logic [NW:0]      dvd_q;
  logic [DW-1:0]    rem_q;
  logic [DW-1:0]    den_q;
  logic             neg_q;
  logic [CNTW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [NW-1:0]    mag;
  logic [DW:0]      rem_sh;
  logic             ge;

  assign mag    = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
  assign rem_sh = {rem_q, dvd_q[NW]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(NW + 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The half-divisor bias is added before the division to round the magnitude.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {1'b0, mag} + (NW + 1)'(den_i >> 1);
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[NW-1];
    end else if (busy_q) begin
      rem_q <= ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
      dvd_q <= {dvd_q[NW-1:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(dvd_q) : $signed(dvd_q);

endmodule

### hdl/gsu_isqrt.sv
// Digit-by-digit floor square root, one result bit per cycle.
module gsu_isqrt import gsu_pkg::*; #(
  parameter int IW = 58
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [IW-1:0]     arg_i,
  output logic              done_o,
  output logic [IW/2-1:0]   root_o
);

  localparam int RTW  = IW / 2;
  localparam int CNTW = $clog2(RTW + 1);

  logic [IW-1:0]    arg_q;
  logic [RTW+1:0]   rem_q;
  logic [RTW-1:0]   root_q;
  logic [CNTW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [RTW+1:0]   rem_sh;
  logic [RTW+1:0]   trial;
  logic             ge;

  assign rem_sh = {rem_q[RTW-1:0], arg_q[IW-1:IW-2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(RTW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      arg_q  <= arg_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[RTW-2:0], ge};
      arg_q  <= arg_q << 2;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### hdl/gsu_cell.sv
// One basis column: its memory, accumulator, coefficient, multiplier and divider.
module gsu_cell import gsu_pkg::*; #(
  parameter int VEC_DIM = 64,
  parameter int J       = 0,
  parameter int CHW     = 36,
  parameter int DENW    = 37
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctl_t             ctl_i,
  input  logic [DENW-1:0]       den_i,
  input  logic signed [CHW-1:0] chain_i,
  output logic signed [CHW-1:0] chain_o,
  output logic signed [XW-1:0]  rdata_o,
  output logic                  done_o
);

  localparam int AW = $clog2(VEC_DIM);

  logic signed [XW-1:0]    mem_q [VEC_DIM];
  logic signed [XW-1:0]    rd_q;
  logic signed [XW-1:0]    y_q;
  logic signed [ACCW-1:0]  acc_q;
  logic signed [PRODW-1:0] prod_q;
  logic signed [CHW-1:0]   chain_q;
  logic [AW-1:0]           addr;
  logic                    sel;
  logic signed [DW_D-1:0]  mul_a;
  logic signed [XW-1:0]    mul_b;
  logic signed [ACCW:0]    acc_sum;
  logic signed [PRODW:0]   quo;
  logic signed [XW-1:0]    wb_val;

  assign addr = ctl_i.addr[AW-1:0];
  assign sel  = ctl_i.col == MAX_CW'(J);

  always_ff @(posedge clk_i) begin
    if (ctl_i.host_wr && sel) begin
      mem_q[addr] <= ctl_i.wdata;
    end else if (ctl_i.wb_en) begin
      mem_q[addr] <= wb_val;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[addr];
    end
  end

  always_comb begin
    case (ctl_i.mul_sel)
      MS_RD_B: begin
        mul_a = DW_D'(rd_q);
        mul_b = ctl_i.bdata[XW-1:0];
      end
      MS_RD_Y: begin
        mul_a = DW_D'(rd_q);
        mul_b = y_q;
      end
      MS_Y_Y: begin
        mul_a = DW_D'(y_q);
        mul_b = y_q;
      end
      default: begin
        mul_a = ctl_i.bdata;
        mul_b = y_q;
      end
    endcase
  end

  // Products of two Q4.12 words fit 32 bits; only the direction product is wider.
  assign acc_sum = (ACCW + 1)'(acc_q) + (ACCW + 1)'($signed(prod_q[DW_D-1:0]));

  always_ff @(posedge clk_i) begin
    prod_q  <= mul_a * mul_b;
    chain_q <= chain_i + CHW'($signed(prod_q[DW_D-1:0]));
    if (ctl_i.y_load) begin
      y_q <= rnd_q12(acc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.y_load) begin
      acc_q <= '0;
    end else if (ctl_i.acc_en) begin
      if (acc_sum[ACCW] != acc_sum[ACCW-1]) begin
        acc_q <= {acc_sum[ACCW], {(ACCW - 1){~acc_sum[ACCW]}}};
      end else begin
        acc_q <= acc_sum[ACCW-1:0];
      end
    end
  end

  gsu_div #(
    .NW (PRODW),
    .DW (DENW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.div_start),
    .num_i   (prod_q),
    .den_i   (den_i),
    .done_o  (done_o),
    .quo_o   (quo)
  );

  assign wb_val  = sat_xw(WIDEW'(rd_q) + WIDEW'(quo));
  assign chain_o = chain_q;
  assign rdata_o = rd_q;

endmodule
